FILE: hw/rtl/mcs_pkg.sv
// Package with the shared types and constants of the max-cut-segments block.
package mcs_pkg;

   localparam int LEN_W       = 10;
   localparam int MAX_LENGTH  = 1023;
   localparam int TABLE_DEPTH = MAX_LENGTH + 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int NUM_LANES   = 3;

   // One item on the request channel.
   typedef struct packed {
      logic [LEN_W-1:0] total_length;
      logic [LEN_W-1:0] first_length;
      logic [LEN_W-1:0] second_length;
      logic [LEN_W-1:0] third_length;
   } req_payload_type;

   // One item on the response channel.
   typedef struct packed {
      logic [LEN_W-1:0] max_pieces;
   } rsp_payload_type;

   // One table entry: a reachable flag and the best piece count.
   typedef struct packed {
      logic             reach;
      logic [LEN_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/mcs_req_if.sv
// Valid/ready channel that carries request items.
interface mcs_req_if;
   import mcs_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mcs_rsp_if.sv
// Valid/ready channel that carries response items.
interface mcs_rsp_if;
   import mcs_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/max_cut_segments_dp_core.sv
// Top level of the max-cut-segments block: table sequencer and its three RAM copies.
// An item of total length T (T > 0) passes from acceptance to the response
// through these steps: accept, seed table entry 0, fill table entries 1..T at
// one entry per cycle, and then the response sits in its register until taken (T = 0
// answers on the cycle after acceptance). The per-entry loop sets the rate: each
// entry needs, for each of the three segment lengths, the entry that one segment
// length back, read from three copies of the table in parallel, and the entry
// just written is forwarded when a segment length is one. The request channel is
// not ready while an item is in work or its response waits. The table needs no
// clearing after reset, since every item writes each entry before reading it.
module max_cut_segments_dp_core (
   input  logic      clock,
   input  logic      reset,
   mcs_req_if.sink   req_ch,
   mcs_rsp_if.source rsp_ch
);
   import mcs_pkg::*;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0] seg_ff [NUM_LANES];
   logic [LEN_W-1:0] seg_in [NUM_LANES];
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [NUM_LANES-1:0] lane_ok_ff, lane_ok_in;
   entry_type        last_ff, last_in;
   logic [LEN_W-1:0] result_ff, result_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_idx;
   logic [ADDR_W-1:0] rd_addr [NUM_LANES];
   logic [ENTRY_W-1:0] rd_data [NUM_LANES];
   entry_type         new_entry;

   // One table copy per segment length, all written with the same entry.
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_table
      mcs_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (TABLE_DEPTH)
      ) u_table (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_addr (rd_addr[k]),
         .rd_data (rd_data[k])
      );
   end

   // Read addresses for the next entry; a lane only counts if its segment fits.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         rd_addr[k]    = rd_idx - seg_ff[k];
         lane_ok_in[k] = (seg_ff[k] != '0) && (seg_ff[k] <= rd_idx);
      end
   end

   // Best count over the three lanes for the entry under work.
   always_comb begin
      entry_type        src;
      logic [LEN_W-1:0] cand;
      new_entry = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         src  = (seg_ff[k] == LEN_W'(1)) ? last_ff : entry_type'(rd_data[k]);
         cand = src.count + LEN_W'(1);
         if (lane_ok_ff[k] && src.reach && (!new_entry.reach || cand > new_entry.count)) begin
            new_entry.reach = 1'b1;
            new_entry.count = cand;
         end
      end
   end

   // Sequencer: next state, table writes and register updates.
   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      result_in = result_ff;
      for (int k = 0; k < NUM_LANES; k++) begin
         seg_in[k] = seg_ff[k];
      end
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = new_entry;
      rd_idx       = idx_ff + ADDR_W'(1);
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               total_in  = req_ch.payload.total_length;
               seg_in[0] = req_ch.payload.first_length;
               seg_in[1] = req_ch.payload.second_length;
               seg_in[2] = req_ch.payload.third_length;
               result_in = '0;
               state_in  = (req_ch.payload.total_length == '0) ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            // Seed entry 0 as reachable with no pieces and start reads for entry 1.
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{reach: 1'b1, count: '0};
            last_in  = '{reach: 1'b1, count: '0};
            rd_idx   = ADDR_W'(1);
            idx_in   = ADDR_W'(1);
            state_in = ST_FILL;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            last_in = new_entry;
            if (idx_ff == ADDR_W'(total_ff)) begin
               result_in = new_entry.reach ? new_entry.count : '0;
               state_in  = ST_DONE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.payload.max_pieces = result_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item data and table bookkeeping.
   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      idx_ff     <= idx_in;
      lane_ok_ff <= lane_ok_in;
      last_ff    <= last_in;
      result_ff  <= result_in;
      for (int k = 0; k < NUM_LANES; k++) begin
         seg_ff[k] <= seg_in[k];
      end
   end

endmodule

FILE: hw/rtl/mcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mcs_checker.sv
// Port-level checker for the max-cut-segments block and its bind.
module mcs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [mcs_pkg::LEN_W-1:0] rsp_max_pieces
);

   // The block works on one item at a time, so it never asks for a new
   // item while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // An accepted item blocks the request channel on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after an accepted item");

   // Taking the response frees the block for the next item.
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("block not idle after its response was taken");

   // A stalled response stays valid with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_max_pieces)))
      else $error("stalled response dropped or changed");

endmodule

bind max_cut_segments_dp_core mcs_checker u_mcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_max_pieces (rsp_ch.payload.max_pieces)
);
